@@ sv/ccp_pkg.sv @@
package ccp_pkg;

    localparam int SUM_BITS    = 48;
    localparam int CAL_BITS    = 32;
    localparam int PERIM_BITS  = 32;
    localparam int CHUNK_BITS  = 16;
    localparam int N_CHUNKS    = SUM_BITS / CHUNK_BITS;
    localparam int PP_BITS     = CHUNK_BITS + CAL_BITS;
    localparam int PROD_BITS   = SUM_BITS + CAL_BITS;
    localparam int FRAC_SHIFT  = 24;
    localparam int MUL_IDX_W   = 2;

    localparam logic [CAL_BITS-1:0] CAL_RESET = CAL_BITS'(65536);

    localparam logic [MUL_IDX_W-1:0] MUL_FIRST = 2'd0;
    localparam logic [MUL_IDX_W-1:0] MUL_LAST  = 2'd3;

    // controller -> datapath commands
    typedef struct packed {
        logic                 load;
        logic                 new_contour;
        logic                 sqrt_init;
        logic                 sel_close;
        logic                 sqrt_step;
        logic                 add_len;
        logic                 upd_prev;
        logic                 mul_step;
        logic [MUL_IDX_W-1:0] mul_idx;
        logic                 out_load;
        logic                 cfg_we;
    } t_cmd;

endpackage

@@ sv/ccp_ctrl.sv @@
module ccp_ctrl #(
    parameter int COORD_BITS = 14
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    input  logic          i_s_tlast,
    output logic          o_s_tready,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    output ccp_pkg::t_cmd o_cmd
);
    import ccp_pkg::*;

    localparam int RH = COORD_BITS + 9;
    localparam int CW = $clog2(RH + 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_INIT = 6'b000010,
        S_SQRT = 6'b000100,
        S_ADD  = 6'b001000,
        S_MUL  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [MUL_IDX_W-1:0]  r_mul_idx, n_mul_idx;
    logic                  r_in_contour, n_in_contour;
    logic                  r_last, n_last;
    logic                  r_closing, n_closing;
    logic                  r_out_valid, n_out_valid;
    logic                  accept;
    logic                  out_free;

    assign o_s_tready  = (r_state == S_IDLE);
    assign accept      = i_s_tvalid && o_s_tready;
    assign out_free    = !r_out_valid || i_m_tready;
    assign o_m_tvalid  = r_out_valid;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_mul_idx    = r_mul_idx;
        n_in_contour = r_in_contour;
        n_last       = r_last;
        n_closing    = r_closing;
        n_out_valid  = r_out_valid;
        o_cmd        = '0;
        o_cmd.cfg_we    = i_cfg_valid;
        o_cmd.sel_close = r_closing;
        o_cmd.mul_idx   = r_mul_idx;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load        = 1'b1;
                    o_cmd.new_contour = !r_in_contour;
                    n_last            = i_s_tlast;
                    if (r_in_contour) begin
                        n_closing = 1'b0;
                        n_state   = S_INIT;
                    end else begin
                        n_in_contour = 1'b1;
                        if (i_s_tlast) begin
                            n_closing = 1'b1;
                            n_state   = S_INIT;
                        end
                    end
                end
            end
            S_INIT: begin
                o_cmd.sqrt_init = 1'b1;
                n_cnt           = '0;
                n_state         = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                n_cnt           = r_cnt + 1'b1;
                if (r_cnt == CW'(RH - 1)) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                o_cmd.add_len = 1'b1;
                if (r_closing) begin
                    n_in_contour = 1'b0;
                    n_mul_idx    = MUL_FIRST;
                    n_state      = S_MUL;
                end else begin
                    o_cmd.upd_prev = 1'b1;
                    if (r_last) begin
                        n_closing = 1'b1;
                        n_state   = S_INIT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_MUL: begin
                // partial product of chunk i registered, chunk i-1 accumulated
                o_cmd.mul_step = 1'b1;
                n_mul_idx      = r_mul_idx + 1'b1;
                if (r_mul_idx == MUL_LAST) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_mul_idx    <= '0;
            r_in_contour <= 1'b0;
            r_last       <= 1'b0;
            r_closing    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_mul_idx    <= n_mul_idx;
            r_in_contour <= n_in_contour;
            r_last       <= n_last;
            r_closing    <= n_closing;
            r_out_valid  <= n_out_valid;
        end
    end

endmodule

@@ sv/ccp_datapath.sv @@
module ccp_datapath #(
    parameter int COORD_BITS = 14
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ccp_pkg::t_cmd                   i_cmd,
    input  logic [COORD_BITS-1:0]           i_x_coord,
    input  logic [COORD_BITS-1:0]           i_y_coord,
    input  logic [ccp_pkg::CAL_BITS-1:0]    i_cfg_data,
    output logic [ccp_pkg::PERIM_BITS-1:0]  o_perimeter,
    output logic                            o_saturated
);
    import ccp_pkg::*;

    localparam int RW = 2 * COORD_BITS + 18;   // radicand: (dx^2+dy^2) << 16
    localparam int RH = RW / 2;                // root bits
    localparam int SQ = 2 * COORD_BITS + 1;

    logic [CAL_BITS-1:0]   r_cal;
    logic [COORD_BITS-1:0] r_first_x, r_first_y, r_prev_x, r_prev_y, r_cur_x, r_cur_y;
    logic [SUM_BITS-1:0]   r_sum;
    logic [RW-1:0]         r_rad;
    logic [RH+1:0]         r_rem;
    logic [RH-1:0]         r_root;
    logic [PP_BITS-1:0]    r_pp;
    logic [PROD_BITS-1:0]  r_acc;
    logic [PERIM_BITS-1:0] r_perim;
    logic                  r_sat;

    logic [COORD_BITS-1:0] ax, ay, bx, by, dx, dy;
    logic [SQ-1:0]         sq;
    logic [RH+3:0]         rem_t, test;
    logic                  ge;
    logic [SUM_BITS:0]     sum_add;
    logic [CHUNK_BITS-1:0] chunk;
    logic [PROD_BITS-1:0]  pp_shift;
    logic                  acc_over;

    always_comb begin
        if (i_cmd.sel_close) begin
            ax = r_cur_x;
            ay = r_cur_y;
            bx = r_first_x;
            by = r_first_y;
        end else begin
            ax = r_prev_x;
            ay = r_prev_y;
            bx = r_cur_x;
            by = r_cur_y;
        end
        dx = (ax > bx) ? (ax - bx) : (bx - ax);
        dy = (ay > by) ? (ay - by) : (by - ay);
        sq = SQ'(dx) * SQ'(dx) + SQ'(dy) * SQ'(dy);
    end

    // one root bit per step
    assign rem_t = {r_rem, r_rad[RW-1 -: 2]};
    assign test  = {2'b00, r_root, 2'b01};
    assign ge    = (rem_t >= test);

    assign sum_add = {1'b0, r_sum} + (SUM_BITS + 1)'(r_root);

    always_comb begin
        case (i_cmd.mul_idx)
            2'd0:    chunk = r_sum[CHUNK_BITS-1:0];
            2'd1:    chunk = r_sum[2*CHUNK_BITS-1:CHUNK_BITS];
            2'd2:    chunk = r_sum[3*CHUNK_BITS-1:2*CHUNK_BITS];
            default: chunk = '0;
        endcase
        case (i_cmd.mul_idx)
            2'd1:    pp_shift = PROD_BITS'(r_pp);
            2'd2:    pp_shift = PROD_BITS'(r_pp) << CHUNK_BITS;
            2'd3:    pp_shift = PROD_BITS'(r_pp) << (2 * CHUNK_BITS);
            default: pp_shift = '0;
        endcase
    end

    assign acc_over = |r_acc[PROD_BITS-1:FRAC_SHIFT+PERIM_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= CAL_RESET;
        end else if (i_cmd.cfg_we) begin
            r_cal <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cur_x <= i_x_coord;
            r_cur_y <= i_y_coord;
            if (i_cmd.new_contour) begin
                r_first_x <= i_x_coord;
                r_first_y <= i_y_coord;
                r_prev_x  <= i_x_coord;
                r_prev_y  <= i_y_coord;
                r_sum     <= '0;
            end
        end
        if (i_cmd.sqrt_init) begin
            r_rad  <= RW'({sq, 16'h0000});
            r_rem  <= '0;
            r_root <= '0;
        end
        if (i_cmd.sqrt_step) begin
            r_rad  <= r_rad << 2;
            r_rem  <= ge ? (RH + 2)'(rem_t - test) : rem_t[RH+1:0];
            r_root <= {r_root[RH-2:0], ge};
        end
        if (i_cmd.add_len) begin
            r_sum <= sum_add[SUM_BITS] ? '1 : sum_add[SUM_BITS-1:0];
        end
        if (i_cmd.upd_prev) begin
            r_prev_x <= r_cur_x;
            r_prev_y <= r_cur_y;
        end
        if (i_cmd.mul_step) begin
            r_pp <= PP_BITS'(chunk) * PP_BITS'(r_cal);
            if (i_cmd.mul_idx == MUL_FIRST) begin
                r_acc <= '0;
            end else begin
                r_acc <= r_acc + pp_shift;
            end
        end
        if (i_cmd.out_load) begin
            r_perim <= acc_over ? '1 : r_acc[FRAC_SHIFT +: PERIM_BITS];
            r_sat   <= acc_over;
        end
    end

    assign o_perimeter = r_perim;
    assign o_saturated = r_sat;

endmodule

@@ sv/closed_contour_perimeter_top.sv @@
// channel  | direction | handshake              | payload
// s        | in        | i_s_tvalid/o_s_tready  | tdata: x_coord, y_coord; tlast: last_vertex
// m        | out       | o_m_tvalid/i_m_tready  | tdata: perimeter; tuser: saturated
// cfg      | in        | i_cfg_valid/o_cfg_ready| i_cfg_data: calibration
//
// Each edge runs a bit-serial square root, COORD_BITS+9 steps (23 at 14 bits).
// A vertex inside a contour runs the states INIT, SQRT and ADD for its edge; the last one
// adds the closing edge, four multiply steps and an output state.
// Synchronous active-low reset; calibration resets to 1.0 (65536).
// The result sits in an output register; a stalled consumer blocks the next result and, with it, the input.
module closed_contour_perimeter_top #(
    parameter int COORD_BITS = 14
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]   i_s_tdata,   // x_coord, y_coord
    input  logic                                i_s_tlast,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [ccp_pkg::PERIM_BITS-1:0]      o_m_tdata,   // perimeter
    output logic                                o_m_tuser,   // saturated
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ccp_pkg::CAL_BITS-1:0]        i_cfg_data
);
    import ccp_pkg::*;

    t_cmd cmd;

    ccp_ctrl #(
        .COORD_BITS(COORD_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tlast  (i_s_tlast),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .o_cmd      (cmd)
    );

    ccp_datapath #(
        .COORD_BITS(COORD_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_x_coord  (i_s_tdata[COORD_BITS-1:0]),
        .i_y_coord  (i_s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .i_cfg_data (i_cfg_data),
        .o_perimeter(o_m_tdata),
        .o_saturated(o_m_tuser)
    );

endmodule

@@ sv/ccp_checker.sv @@
module ccp_checker #(
    parameter int COORD_BITS = 14
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_s_tvalid,
    input logic                                o_s_tready,
    input logic [((2*COORD_BITS+7)/8)*8-1:0]   i_s_tdata,
    input logic                                i_s_tlast,
    input logic                                o_m_tvalid,
    input logic                                i_m_tready,
    input logic [ccp_pkg::PERIM_BITS-1:0]      o_m_tdata,
    input logic                                o_m_tuser
);

    // a held result does not change
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    // saturation flag implies clipped value
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata == '1)
        else $error("saturated result not clipped");

    // last vertex always needs the closing edge, so the block goes busy
    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tlast |=> !o_s_tready)
        else $error("ready right after last vertex");

    // a new result never directly follows an accepted vertex
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> !$past(i_s_tvalid && o_s_tready))
        else $error("result appeared without computing");

endmodule

bind closed_contour_perimeter_top ccp_checker #(
    .COORD_BITS(COORD_BITS)
) u_ccp_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_s_tvalid(i_s_tvalid),
    .o_s_tready(o_s_tready),
    .i_s_tdata (i_s_tdata),
    .i_s_tlast (i_s_tlast),
    .o_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready),
    .o_m_tdata (o_m_tdata),
    .o_m_tuser (o_m_tuser)
);

@@ tb/closed_contour_perimeter_checker.sv @@
module closed_contour_perimeter_checker #(
    parameter int COORD_BITS = 14
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    input  logic                                i_s_tready,
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]   i_s_tdata,   // x_coord, y_coord
    input  logic                                i_s_tlast,
    input  logic                                i_m_tvalid,
    input  logic                                i_m_tready,
    input  logic [ccp_pkg::PERIM_BITS-1:0]      i_m_tdata,   // perimeter
    input  logic                                i_m_tuser,   // saturated
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [ccp_pkg::CAL_BITS-1:0]        i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_open_results
);
    timeunit 1ns;
    timeprecision 1ps;

    import ccp_pkg::*;

    typedef struct packed {
        logic [PERIM_BITS-1:0] perimeter;
        logic                  saturated;
    } t_perim_result;

    t_perim_result           perim_q[$];

    logic [COORD_BITS-1:0]   start_x, start_y;
    logic [COORD_BITS-1:0]   last_x, last_y;
    logic [SUM_BITS-1:0]     run_length;
    logic                    open_contour;
    logic [CAL_BITS-1:0]     cal_factor;

    initial o_fail_count = 0;

    // edge length with 8 fraction bits, truncated
    function automatic logic [SUM_BITS-1:0] edge_length(
        input logic [COORD_BITS-1:0] ax,
        input logic [COORD_BITS-1:0] ay,
        input logic [COORD_BITS-1:0] bx,
        input logic [COORD_BITS-1:0] by
    );
        logic [63:0] dx, dy, radicand, root, trial;
        dx = (ax > bx) ? 64'(ax) - 64'(bx) : 64'(bx) - 64'(ax);
        dy = (ay > by) ? 64'(ay) - 64'(by) : 64'(by) - 64'(ay);
        radicand = (dx * dx + dy * dy) << 16;
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= radicand) begin
                root = trial;
            end
        end
        return SUM_BITS'(root);
    endfunction

    function automatic logic [SUM_BITS-1:0] add_length(
        input logic [SUM_BITS-1:0] total,
        input logic [SUM_BITS-1:0] len
    );
        logic [SUM_BITS:0] s;
        s = {1'b0, total} + {1'b0, len};
        return s[SUM_BITS] ? {SUM_BITS{1'b1}} : s[SUM_BITS-1:0];
    endfunction

    always @(posedge i_clk) begin
        t_perim_result             want;
        logic [COORD_BITS-1:0]     vx, vy;
        logic [PROD_BITS-1:0]      scaled;
        if (!i_rst_n) begin
            start_x      = '0;
            start_y      = '0;
            last_x       = '0;
            last_y       = '0;
            run_length   = '0;
            open_contour = 1'b0;
            cal_factor   = CAL_RESET;
            perim_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                cal_factor = i_cfg_data;
            end

            if (i_m_tvalid && i_m_tready) begin
                if (perim_q.size() == 0) begin
                    $display("%0t: result expected none actual perimeter %h saturated %b",
                             $time, i_m_tdata, i_m_tuser);
                    o_fail_count++;
                end else begin
                    want = perim_q.pop_front();
                    if (i_m_tdata !== want.perimeter) begin
                        $display("%0t: perimeter expected %h actual %h",
                                 $time, want.perimeter, i_m_tdata);
                        o_fail_count++;
                    end
                    if (i_m_tuser !== want.saturated) begin
                        $display("%0t: saturated expected %b actual %b",
                                 $time, want.saturated, i_m_tuser);
                        o_fail_count++;
                    end
                end
            end

            if (i_s_tvalid && i_s_tready) begin
                vx = i_s_tdata[COORD_BITS-1:0];
                vy = i_s_tdata[2*COORD_BITS-1:COORD_BITS];
                if (!open_contour) begin
                    start_x      = vx;
                    start_y      = vy;
                    run_length   = '0;
                    open_contour = 1'b1;
                end else begin
                    run_length = add_length(run_length, edge_length(last_x, last_y, vx, vy));
                end
                last_x = vx;
                last_y = vy;
                if (i_s_tlast) begin
                    // closing edge back to the first vertex
                    run_length   = add_length(run_length,
                                              edge_length(vx, vy, start_x, start_y));
                    open_contour = 1'b0;
                    scaled = (PROD_BITS'(run_length) * PROD_BITS'(cal_factor)) >> FRAC_SHIFT;
                    if (scaled > PROD_BITS'({PERIM_BITS{1'b1}})) begin
                        want.perimeter = '1;
                        want.saturated = 1'b1;
                    end else begin
                        want.perimeter = scaled[PERIM_BITS-1:0];
                        want.saturated = 1'b0;
                    end
                    perim_q = {perim_q, want};
                end
            end
        end
        o_open_results <= perim_q.size();
    end

endmodule

@@ tb/closed_contour_perimeter_top_tb.sv @@
module closed_contour_perimeter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS      = 14;
    localparam int TDATA_W         = ((2*COORD_BITS+7)/8)*8;
    localparam int SETTLE_CYCLES   = 2*(COORD_BITS+11)+14;
    localparam int HOLDOFF_CYCLES  = 600;
    localparam int ITEMS_PER_PHASE = 220;

    localparam logic [COORD_BITS-1:0]        COORD_MAX = '1;
    localparam logic [ccp_pkg::CAL_BITS-1:0] CAL_MAX   = '1;
    localparam logic [ccp_pkg::CAL_BITS-1:0] CAL_ZERO  = '0;
    localparam logic [ccp_pkg::CAL_BITS-1:0] CAL_1P5   = 32'h0001_8000;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_s_tvalid;
    logic                              o_s_tready;
    logic [TDATA_W-1:0]                i_s_tdata;   // x_coord, y_coord
    logic                              i_s_tlast;
    logic                              o_m_tvalid;
    logic                              i_m_tready;
    logic [ccp_pkg::PERIM_BITS-1:0]    o_m_tdata;   // perimeter
    logic                              o_m_tuser;   // saturated
    logic                              i_cfg_valid;
    logic                              o_cfg_ready;
    logic [ccp_pkg::CAL_BITS-1:0]      i_cfg_data;

    int   fail_count;
    int   open_results;
    int   src_idle_pct   = 0;
    int   sink_stall_pct = 0;
    int   items_sent     = 0;
    logic sink_hold      = 1'b0;
    logic holdoff_req    = 1'b0;

    closed_contour_perimeter_top #(
        .COORD_BITS (COORD_BITS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    closed_contour_perimeter_checker #(
        .COORD_BITS (COORD_BITS)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_tvalid     (i_s_tvalid),
        .i_s_tready     (o_s_tready),
        .i_s_tdata      (i_s_tdata),
        .i_s_tlast      (i_s_tlast),
        .i_m_tvalid     (o_m_tvalid),
        .i_m_tready     (i_m_tready),
        .i_m_tdata      (o_m_tdata),
        .i_m_tuser      (o_m_tuser),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_open_results (open_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            i_m_tready <= sink_hold ? 1'b0 : ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // long consumer hold-off so the block backs up and stalls its input
    initial begin
        wait (holdoff_req);
        @(posedge i_clk);
        sink_hold <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge i_clk);
        sink_hold <= 1'b0;
    end

    initial begin
        #5_000_000;
        $display("closed_contour_perimeter_top_tb: FAIL");
        $finish;
    end

    // returns at the edge where the request is taken; valid stays up
    task automatic send_vertex(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
                               input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= TDATA_W'({y, x});
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        items_sent++;
    endtask

    // wait until every result is out and the block has gone quiet
    task automatic settle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (open_results != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_calibration(input logic [ccp_pkg::CAL_BITS-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_zigzag();
        send_vertex('0, '0, 1'b0);
        send_vertex(COORD_MAX, COORD_MAX, 1'b0);
        send_vertex('0, '0, 1'b0);
        send_vertex(COORD_MAX, COORD_MAX, 1'b1);
    endtask

    task automatic send_contour();
        int n;
        int style;
        logic [COORD_BITS-1:0] x, y;
        n = ($urandom_range(99) < 10) ? $urandom_range(40, 8) : $urandom_range(6, 1);
        style = $urandom_range(2);
        x = COORD_BITS'($urandom);
        y = COORD_BITS'($urandom);
        for (int k = 0; k < n; k++) begin
            case (style)
                0: begin
                    x = COORD_BITS'($urandom);
                    y = COORD_BITS'($urandom);
                end
                1: begin
                    // short steps around a random start, wrapping at the edges
                    x = x + COORD_BITS'($urandom_range(64)) - COORD_BITS'(32);
                    y = y + COORD_BITS'($urandom_range(64)) - COORD_BITS'(32);
                end
                default: begin
                    x = $urandom_range(1) ? COORD_MAX : '0;
                    y = $urandom_range(1) ? COORD_MAX : '0;
                end
            endcase
            send_vertex(x, y, k == n - 1);
        end
    endtask

    task automatic run_phase(input int src_pct, input int sink_pct,
                             input logic [ccp_pkg::CAL_BITS-1:0] cal);
        int first_item;
        settle();
        write_calibration(cal);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        first_item     = items_sent;
        while (items_sent - first_item < ITEMS_PER_PHASE) begin
            send_contour();
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tlast   = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single-vertex contours at both corners
        send_vertex('0, '0, 1'b1);
        send_vertex(COORD_MAX, COORD_MAX, 1'b1);
        // full-size square
        send_vertex('0, '0, 1'b0);
        send_vertex(COORD_MAX, '0, 1'b0);
        send_vertex(COORD_MAX, COORD_MAX, 1'b0);
        send_vertex('0, COORD_MAX, 1'b1);
        // long diagonals: large but unscaled
        send_zigzag();
        settle();
        write_calibration(CAL_MAX);
        send_zigzag();
        settle();
        write_calibration(CAL_ZERO);
        send_vertex(14'd3, 14'd4, 1'b0);
        send_vertex(14'd100, 14'd9000, 1'b0);
        send_vertex(14'd16000, 14'd2, 1'b1);
        settle();
        // calibration changed while a contour is open
        write_calibration(ccp_pkg::CAL_RESET);
        send_vertex(14'd5, 14'd7, 1'b0);
        settle();
        write_calibration(CAL_1P5);
        send_vertex(14'd100, 14'd3000, 1'b1);

        run_phase(0, 0, ccp_pkg::CAL_RESET);
        holdoff_req = 1'b1;
        repeat (20) begin
            send_vertex(COORD_BITS'($urandom), COORD_BITS'($urandom), 1'b0);
            send_vertex(COORD_BITS'($urandom), COORD_BITS'($urandom), 1'b1);
        end
        run_phase(84, 0, CAL_MAX);
        run_phase(0, 84, $urandom);
        run_phase(13, 13, 32'd1);
        run_phase(13, 13, $urandom);
        settle();

        if (fail_count == 0) begin
            $display("closed_contour_perimeter_top_tb: PASS");
        end else begin
            $display("closed_contour_perimeter_top_tb: FAIL");
        end
        $finish;
    end

endmodule
